[rtl/cvwf_pkg.sv]
// Shared widths, register codes, types and helpers for the 3x3 valid-window filter.
package cvwf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MAX_KERNEL     = 3;
    localparam int WIN            = 3;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int KER_W      = 2;
    localparam int COEF_W     = 16;
    localparam int COEF_ROW_W = 48;
    localparam int PROD_W     = 24;
    localparam int ROW_SUM_W  = 26;
    localparam int SUM_W      = 28;
    // position arithmetic: holds values up to 16383
    localparam int CALC_W     = 14;

    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW0    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW1    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW2    = 3'd6;

    typedef struct packed {
        logic [DIM_W-1:0]                 image_width;
        logic [DIM_W-1:0]                 image_height;
        logic [KER_W-1:0]                 kernel_rows;
        logic [KER_W-1:0]                 kernel_cols;
        logic [WIN-1:0][COEF_ROW_W-1:0]   coef_row;
    } cfg_t;

    // window[row][col], row 2 is the newest row, col 2 the newest column
    typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] window_t;

    function automatic logic [KER_W-1:0] clamp_kernel(input logic [KER_W-1:0] k);
        if (k == '0)
            return KER_W'(1);
        if (k > KER_W'(MAX_KERNEL))
            return KER_W'(MAX_KERNEL);
        return k;
    endfunction

    function automatic logic [CALC_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                    input logic [CALC_W-1:0] hi);
        if (v == '0)
            return CALC_W'(1);
        if (CALC_W'(v) > hi)
            return hi;
        return CALC_W'(v);
    endfunction

endpackage

[rtl/cvwf_cfg_regs.sv]
// APB register file: image size, kernel size and coefficient rows.
module cvwf_cfg_regs
    import cvwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [DIM_W-1:0]               image_width_reg;
    logic [DIM_W-1:0]               image_height_reg;
    logic [KER_W-1:0]               kernel_rows_reg;
    logic [KER_W-1:0]               kernel_cols_reg;
    logic [WIN-1:0][COEF_ROW_W-1:0] coef_row_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[PADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_W'(4);
            image_height_reg <= DIM_W'(6);
            kernel_rows_reg  <= KER_W'(3);
            kernel_cols_reg  <= KER_W'(3);
            coef_row_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_KERNEL_ROWS:  kernel_rows_reg  <= pwdata[KER_W-1:0];
                REG_KERNEL_COLS:  kernel_cols_reg  <= pwdata[KER_W-1:0];
                REG_COEF_ROW0:    coef_row_reg[0]  <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_ROW1:    coef_row_reg[1]  <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_ROW2:    coef_row_reg[2]  <= pwdata[COEF_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height_reg);
            REG_KERNEL_ROWS:  prdata = PDATA_W'(kernel_rows_reg);
            REG_KERNEL_COLS:  prdata = PDATA_W'(kernel_cols_reg);
            REG_COEF_ROW0:    prdata = PDATA_W'(coef_row_reg[0]);
            REG_COEF_ROW1:    prdata = PDATA_W'(coef_row_reg[1]);
            REG_COEF_ROW2:    prdata = PDATA_W'(coef_row_reg[2]);
            default:          prdata = '0;
        endcase
    end

    assign cfg.image_width  = image_width_reg;
    assign cfg.image_height = image_height_reg;
    assign cfg.kernel_rows  = kernel_rows_reg;
    assign cfg.kernel_cols  = kernel_cols_reg;
    assign cfg.coef_row     = coef_row_reg;

endmodule

[rtl/cvwf_line_store.sv]
// Two line banks, read both and write one at the same column, read-first.
module cvwf_line_store
    import cvwf_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    addr,
    input  logic             wr_bank,
    input  logic [PIX_W-1:0] wr_data,
    output logic [PIX_W-1:0] rd0,
    output logic [PIX_W-1:0] rd1
);

    logic [PIX_W-1:0] bank0_mem [DEPTH];
    logic [PIX_W-1:0] bank1_mem [DEPTH];
    logic [PIX_W-1:0] rd0_reg;
    logic [PIX_W-1:0] rd1_reg;

    // read returns the old contents; the write is seen by the next access
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd0_reg <= bank0_mem[addr];
            rd1_reg <= bank1_mem[addr];
            if (wr_bank)
                bank1_mem[addr] <= wr_data;
            else
                bank0_mem[addr] <= wr_data;
        end
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

[rtl/cvwf_mac.sv]
// Window multiply-accumulate: product, row-sum and output stages with handshake.
module cvwf_mac
    import cvwf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    win_valid,
    output logic                    win_ready,
    input  window_t                 window,
    input  logic                    win_last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] conv_sum,
    output logic                    frame_last
);

    logic                                p_valid_reg;
    logic                                p_last_reg;
    logic [WIN-1:0][WIN-1:0][PROD_W-1:0] prod_reg;
    logic [WIN-1:0][WIN-1:0][PROD_W-1:0] prod_next;

    logic                           s_valid_reg;
    logic                           s_last_reg;
    logic [WIN-1:0][ROW_SUM_W-1:0]  row_sum_reg;
    logic [WIN-1:0][ROW_SUM_W-1:0]  row_sum_next;

    logic                    o_valid_reg;
    logic                    o_last_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    logic             o_free;
    logic             s_free;
    logic             p_free;
    logic [KER_W-1:0] kr_c;
    logic [KER_W-1:0] kc_c;
    logic [KER_W-1:0] row_off;
    logic [KER_W-1:0] col_off;

    assign o_free    = !o_valid_reg || out_ready;
    assign s_free    = !s_valid_reg || o_free;
    assign p_free    = !p_valid_reg || s_free;
    assign win_ready = p_free;

    assign kr_c    = clamp_kernel(cfg.kernel_rows);
    assign kc_c    = clamp_kernel(cfg.kernel_cols);
    // kernel sits at the bottom-right corner of the window
    assign row_off = KER_W'(WIN) - kr_c;
    assign col_off = KER_W'(WIN) - kc_c;

    always_comb
    begin
        logic signed [PIX_W+COEF_W:0] full;
        full = '0;
        prod_next = '0;
        for (int j = 0; j < WIN; j++)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                if (KER_W'(j) < kr_c && KER_W'(i) < kc_c)
                begin
                    full = $signed({1'b0, window[row_off + KER_W'(j)][col_off + KER_W'(i)]})
                         * $signed(cfg.coef_row[j][COEF_W*i +: COEF_W]);
                    prod_next[j][i] = full[PROD_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < WIN; j++)
        begin
            row_sum_next[j] = ROW_SUM_W'($signed(prod_reg[j][0]))
                            + ROW_SUM_W'($signed(prod_reg[j][1]))
                            + ROW_SUM_W'($signed(prod_reg[j][2]));
        end
        sum_next = SUM_W'($signed(row_sum_reg[0]))
                 + SUM_W'($signed(row_sum_reg[1]))
                 + SUM_W'($signed(row_sum_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
                p_valid_reg <= win_valid;
            if (s_free)
                s_valid_reg <= p_valid_reg;
            if (o_free)
                o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid && p_free)
        begin
            prod_reg   <= prod_next;
            p_last_reg <= win_last;
        end
        if (p_valid_reg && s_free)
        begin
            row_sum_reg <= row_sum_next;
            s_last_reg  <= p_last_reg;
        end
        if (s_valid_reg && o_free)
        begin
            sum_reg    <= sum_next;
            o_last_reg <= s_last_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign conv_sum   = sum_reg;
    assign frame_last = o_last_reg;

endmodule

[rtl/conv2d_valid_window_filter.sv]
// Top level of the streaming 3x3 valid-window filter.
//
//   channel   dir   handshake               word
//   pixel     in    in_valid / in_ready     pixel[7:0]
//   result    out   out_valid / out_ready   conv_sum[27:0], frame_last
//   config    in    APB psel/penable        paddr[5:0] (8*index), pwdata[63:0]
//
// One pixel per clock sustained; a stalled output holds all stages behind it.
// A pixel reads both line banks at its column on accept; the sum shows on
// out_valid after the bank read, window shift, products, row sums and output
// register that follow the accept of the window's bottom-right pixel. Reset
// clears counters, window and stage valids; the line banks are not cleared.
module conv2d_valid_window_filter
    import cvwf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PIX_W-1:0]        pixel,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] conv_sum,
    output logic                    frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    cfg_t cfg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_bank_reg;
    logic [PIX_W-1:0] s1_pixel_reg;

    logic             s2_valid_reg;
    logic             s2_last_reg;
    window_t          window_reg;
    window_t          window_next;

    logic             accept;
    logic             adv1;
    logic             s2_free;
    logic             win_ready;
    logic [PIX_W-1:0] rd0;
    logic [PIX_W-1:0] rd1;
    logic [PIX_W-1:0] old_px;
    logic [PIX_W-1:0] prev_px;

    logic [CALC_W-1:0] w_c;
    logic [CALC_W-1:0] h_c;
    logic [KER_W-1:0]  kr_c;
    logic [KER_W-1:0]  kc_c;
    logic [CALC_W-1:0] kr1;
    logic [CALC_W-1:0] kc1;
    logic [CALC_W-1:0] bound_r;
    logic [CALC_W-1:0] bound_c;
    logic [CALC_W-1:0] c_ext;
    logic [CALC_W-1:0] r_ext;
    logic              emit;
    logic              last;

    cvwf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // bank row[0] holds row r-2 and takes the new pixel; the other holds r-1
    cvwf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .en      (accept),
        .addr    (col_reg),
        .wr_bank (row_reg[0]),
        .wr_data (pixel),
        .rd0     (rd0),
        .rd1     (rd1)
    );

    assign s2_free  = !s2_valid_reg || win_ready;
    assign adv1     = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || adv1;
    assign accept   = in_valid && in_ready;

    // valid-area test for the incoming pixel
    assign w_c     = clamp_dim(cfg.image_width, CALC_W'(MAX_WIDTH));
    assign h_c     = clamp_dim(cfg.image_height, CALC_W'(MAX_HEIGHT));
    assign kr_c    = clamp_kernel(cfg.kernel_rows);
    assign kc_c    = clamp_kernel(cfg.kernel_cols);
    assign kr1     = CALC_W'(kr_c) - CALC_W'(1);
    assign kc1     = CALC_W'(kc_c) - CALC_W'(1);
    // row and column bounds for emit: size + k - 1 - 2*floor(k/2), equal to out + k - 1 only for odd k
    assign bound_r = h_c + kr1 - CALC_W'({kr_c[KER_W-1:1], 1'b0});
    assign bound_c = w_c + kc1 - CALC_W'({kc_c[KER_W-1:1], 1'b0});
    assign c_ext   = CALC_W'(col_reg);
    assign r_ext   = CALC_W'(row_reg);
    assign emit    = (r_ext >= kr1) && (c_ext >= kc1) && (r_ext < bound_r) && (c_ext < bound_c);
    assign last    = (r_ext == bound_r - CALC_W'(1)) && (c_ext == bound_c - CALC_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (c_ext + CALC_W'(1) >= w_c)
        begin
            col_next = '0;
            if (r_ext + CALC_W'(1) >= h_c)
                row_next = '0;
            else
                row_next = ROW_W'(r_ext + CALC_W'(1));
        end
        else
        begin
            col_next = COL_W'(c_ext + CALC_W'(1));
        end
    end

    assign old_px  = s1_bank_reg ? rd1 : rd0;
    assign prev_px = s1_bank_reg ? rd0 : rd1;

    always_comb
    begin
        window_next = window_reg;
        for (int j = 0; j < WIN; j++)
        begin
            window_next[j][0] = window_reg[j][1];
            window_next[j][1] = window_reg[j][2];
        end
        window_next[0][2] = old_px;
        window_next[1][2] = prev_px;
        window_next[2][2] = s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (adv1)
                window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_bank_reg  <= row_reg[0];
            s1_pixel_reg <= pixel;
        end
        if (adv1)
            s2_last_reg <= s1_last_reg;
    end

    cvwf_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .win_valid  (s2_valid_reg),
        .win_ready  (win_ready),
        .window     (window_reg),
        .win_last   (s2_last_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .conv_sum   (conv_sum),
        .frame_last (frame_last)
    );

endmodule
